### hw/rtl/sidta_pkg.sv
package sidta_pkg;

   localparam logic [7:0] CH_MINUS = 8'd45;
   localparam logic [7:0] CH_ZERO  = 8'd48;

   // shift-add-3 steps done per conversion cycle
   localparam int DD_STEPS = 4;

   // entries in the queue between front and back
   localparam int Q_DEPTH = 2;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_flags_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CONV,
      ST_NORM,
      ST_SIGN,
      ST_DIGIT
   } back_state_type;

endpackage

### hw/rtl/sidta_front.sv
module sidta_front #(
   parameter int VALUE_BITS = 32
) (
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic [VALUE_BITS-1:0]        req_value,
   input  sidta_pkg::queue_flags_type   q_flags,
   output logic                         q_push,
   output logic [VALUE_BITS:0]          q_data
);
   import sidta_pkg::*;

   logic                  neg;
   logic [VALUE_BITS-1:0] mag;

   // sign and magnitude; the most negative value negates onto itself,
   // which read unsigned is the exact magnitude
   assign neg = req_value[VALUE_BITS-1];
   assign mag = neg ? (~req_value + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : req_value;

   assign req_stall = q_flags.full;
   assign q_push    = req_valid && !q_flags.full;
   assign q_data    = {neg, mag};

endmodule

### hw/rtl/sidta_queue.sv
module sidta_queue #(
   parameter int WIDTH = 33
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  logic [WIDTH-1:0]            push_data,
   input  logic                        pop,
   output logic [WIDTH-1:0]            pop_data,
   output sidta_pkg::queue_flags_type  flags
);
   import sidta_pkg::*;

   localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int CW = $clog2(Q_DEPTH + 1);

   logic [WIDTH-1:0] data_ff [Q_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff,  count_in;
   logic             do_push, do_pop;

   function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
      return (p == PW'(Q_DEPTH - 1)) ? '0 : p + PW'(1);
   endfunction

   assign do_push = push && (count_ff != CW'(Q_DEPTH));
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = do_push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + {{(CW-1){1'b0}}, 1'b1};
      end else if (do_pop && !do_push) begin
         count_in = count_ff - {{(CW-1){1'b0}}, 1'b1};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         data_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data        = data_ff[rd_ptr_ff];
   assign flags.not_empty = (count_ff != '0);
   assign flags.full      = (count_ff == CW'(Q_DEPTH));

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(Q_DEPTH))
      else $error("queue count beyond depth");

   a_ptrs_match_when_empty: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue empty but pointers differ");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> (count_ff != '0))
      else $error("push left queue empty");

endmodule

### hw/rtl/sidta_back.sv
module sidta_back #(
   parameter int VALUE_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  sidta_pkg::queue_flags_type  q_flags,
   input  logic [VALUE_BITS:0]         q_data,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [7:0]                  rsp_char_out,
   output logic                        rsp_last_char
);
   import sidta_pkg::*;

   localparam int NDIG = (VALUE_BITS * 30103) / 100000 + 1;
   localparam int BCDW = 4 * NDIG;
   localparam int ITER = (VALUE_BITS + DD_STEPS - 1) / DD_STEPS;
   localparam int PADW = ITER * DD_STEPS;
   localparam int IW   = $clog2(ITER + 1);
   localparam int CW   = $clog2(NDIG + 1);

   back_state_type  state_ff, state_in;
   logic [PADW-1:0] shreg_ff, shreg_in;
   logic [BCDW-1:0] bcd_ff,   bcd_in;
   logic            neg_ff,   neg_in;
   logic [IW-1:0]   iter_ff,  iter_in;
   logic [CW-1:0]   left_ff,  left_in;
   logic            rsp_valid_ff, rsp_valid_in;
   logic [7:0]      rsp_char_ff,  rsp_char_in;
   logic            rsp_last_ff,  rsp_last_in;

   logic [BCDW-1:0] conv_bcd;
   logic [PADW-1:0] conv_sh;
   logic [CW-1:0]   lz;
   logic            out_free;
   logic [3:0]      top_nib;

   // shift-add-3, several bits per cycle
   always_comb begin
      logic [BCDW-1:0] b;
      logic [PADW-1:0] s;
      b = bcd_ff;
      s = shreg_ff;
      for (int st = 0; st < DD_STEPS; st++) begin
         for (int d = 0; d < NDIG; d++) begin
            if (b[4*d +: 4] >= 4'd5) begin
               b[4*d +: 4] = b[4*d +: 4] + 4'd3;
            end
         end
         {b, s} = {b[BCDW-2:0], s, 1'b0};
      end
      conv_bcd = b;
      conv_sh  = s;
   end

   // leading zero digits, keeping at least one digit
   always_comb begin
      logic found;
      found = 1'b0;
      lz    = '0;
      for (int i = NDIG - 1; i >= 1; i--) begin
         if (!found && (bcd_ff[4*i +: 4] == 4'd0)) begin
            lz = lz + {{(CW-1){1'b0}}, 1'b1};
         end else begin
            found = 1'b1;
         end
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign top_nib  = bcd_ff[BCDW-1 -: 4];

   always_comb begin
      state_in     = state_ff;
      shreg_in     = shreg_ff;
      bcd_in       = bcd_ff;
      neg_in       = neg_ff;
      iter_in      = iter_ff;
      left_in      = left_ff;
      rsp_valid_in = out_free ? 1'b0 : rsp_valid_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_last_in  = rsp_last_ff;
      q_pop        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_flags.not_empty) begin
               q_pop    = 1'b1;
               neg_in   = q_data[VALUE_BITS];
               // zero padding goes in first so it never reaches the digits
               shreg_in = PADW'(q_data[VALUE_BITS-1:0]);
               bcd_in   = '0;
               iter_in  = IW'(ITER);
               state_in = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in   = conv_bcd;
            shreg_in = conv_sh;
            iter_in  = iter_ff - {{(IW-1){1'b0}}, 1'b1};
            if (iter_ff == {{(IW-1){1'b0}}, 1'b1}) begin
               state_in = ST_NORM;
            end
         end
         ST_NORM: begin
            bcd_in   = bcd_ff << {lz, 2'b00};
            left_in  = CW'(NDIG) - lz;
            state_in = neg_ff ? ST_SIGN : ST_DIGIT;
         end
         ST_SIGN: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_MINUS;
               rsp_last_in  = 1'b0;
               state_in     = ST_DIGIT;
            end
         end
         ST_DIGIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_char_in  = CH_ZERO + {4'd0, top_nib};
               rsp_last_in  = (left_ff == {{(CW-1){1'b0}}, 1'b1});
               bcd_in       = {bcd_ff[BCDW-5:0], 4'd0};
               left_in      = left_ff - {{(CW-1){1'b0}}, 1'b1};
               if (left_ff == {{(CW-1){1'b0}}, 1'b1}) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shreg_ff    <= shreg_in;
      bcd_ff      <= bcd_in;
      neg_ff      <= neg_in;
      iter_ff     <= iter_in;
      left_ff     <= left_in;
      rsp_char_ff <= rsp_char_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_char_out  = rsp_char_ff;
   assign rsp_last_char = rsp_last_ff;

   a_conv_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CONV) |-> (iter_ff != '0))
      else $error("conversion with no iterations left");

   a_digits_left: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIGIT) |-> (left_ff != '0) && (left_ff <= CW'(NDIG)))
      else $error("digit count out of range");

   a_no_leading_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SIGN || state_ff == ST_DIGIT) && ($past(state_ff) == ST_NORM)
      |-> (top_nib != 4'd0) || (left_ff == {{(CW-1){1'b0}}, 1'b1}))
      else $error("leading zero left after normalising");

   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> (state_ff == ST_CONV))
      else $error("popped item did not start conversion");

endmodule

### hw/rtl/signed_int_to_decimal_ascii.sv
// channel   ports                                        direction
// req       req_valid, req_stall, req_value              in
// rsp       rsp_valid, rsp_stall, rsp_char_out,          out
//           rsp_last_char
//
// Per item: the back takes it off the queue, runs the shift-add-3
// conversion (4 bits a cycle), strips leading zeros, then sends one
// character per cycle while rsp is not stalled.
// The front takes up to two items ahead while the back converts.
// Reset is synchronous and active high; it empties the queue and output.
// A stall on rsp holds the character; a full queue stalls req.
module signed_int_to_decimal_ascii #(
   parameter int VALUE_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [VALUE_BITS-1:0] req_value,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_char_out,
   output logic                  rsp_last_char
);
   import sidta_pkg::*;

   queue_flags_type       q_flags;
   logic                  q_push;
   logic                  q_pop;
   logic [VALUE_BITS:0]   q_in_data;
   logic [VALUE_BITS:0]   q_out_data;

   sidta_front #(
      .VALUE_BITS (VALUE_BITS)
   ) u_front (
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_value (req_value),
      .q_flags   (q_flags),
      .q_push    (q_push),
      .q_data    (q_in_data)
   );

   sidta_queue #(
      .WIDTH (VALUE_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_in_data),
      .pop       (q_pop),
      .pop_data  (q_out_data),
      .flags     (q_flags)
   );

   sidta_back #(
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_flags       (q_flags),
      .q_data        (q_out_data),
      .q_pop         (q_pop),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_char_out  (rsp_char_out),
      .rsp_last_char (rsp_last_char)
   );

endmodule
